[rtl/order_book_price_levels_assert.svh]
// ----------------------------------------------------------------------------
// Order book assertion macros
// Shared concurrent assertion forms for the order book RTL.
// ----------------------------------------------------------------------------
`ifndef ORDER_BOOK_PRICE_LEVELS_ASSERT_SVH
`define ORDER_BOOK_PRICE_LEVELS_ASSERT_SVH

// Check that a condition holds at every edge out of reset.
`define OBPL_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("order book assertion failed");

// Check that a trigger is followed by a condition on the next edge.
`define OBPL_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("order book assertion failed");

`endif

[rtl/obpl_pkg.sv]
// ----------------------------------------------------------------------------
// Order book package
// Sizes, codes and control types shared by the order book modules.
// ----------------------------------------------------------------------------
`default_nettype none
package obpl_pkg;
    localparam int LEVELS  = 64;
    localparam int CNT_W   = $clog2(LEVELS + 1);
    localparam int PRICE_W = 48;
    localparam int QTY_W   = 48;
    localparam int ID_W    = 64;

    typedef enum logic [1:0] {
        KIND_DIFF_LEVEL  = 2'd0,
        KIND_DIFF_COMMIT = 2'd1,
        KIND_SNAP_CLEAR  = 2'd2,
        KIND_SNAP_LEVEL  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic apply;
    } cmd_t;
endpackage
`default_nettype wire

[rtl/obpl_if.sv]
// ----------------------------------------------------------------------------
// Order book channels
// Valid/ready channels for update items and best-level results.
// ----------------------------------------------------------------------------
`default_nettype none
interface obpl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        side;
    logic [47:0] price;
    logic [47:0] quantity;
    logic [63:0] update_id;
    modport source (output valid, kind, side, price, quantity, update_id, input ready);
    modport sink (input valid, kind, side, price, quantity, update_id, output ready);
endinterface

interface obpl_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] best_bid_price;
    logic [47:0] best_bid_qty;
    logic        bid_valid;
    logic [47:0] best_ask_price;
    logic [47:0] best_ask_qty;
    logic        ask_valid;
    logic        ignored;
    logic        table_full;
    modport source (output valid, best_bid_price, best_bid_qty, bid_valid,
                    best_ask_price, best_ask_qty, ask_valid, ignored, table_full,
                    input ready);
    modport sink (input valid, best_bid_price, best_bid_qty, bid_valid,
                  best_ask_price, best_ask_qty, ask_valid, ignored, table_full,
                  output ready);
endinterface
`default_nettype wire

[rtl/obpl_ctrl.sv]
// ----------------------------------------------------------------------------
// Order book controller
// Sequences accept, table update and result beat for one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none
`include "order_book_price_levels_assert.svh"
module obpl_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output obpl_pkg::cmd_t     cmd
);
    obpl_pkg::state_t state_reg;
    obpl_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= obpl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        case (state_reg)
            obpl_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = obpl_pkg::ST_APPLY;
                end
            end
            obpl_pkg::ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = obpl_pkg::ST_DONE;
            end
            obpl_pkg::ST_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = obpl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = obpl_pkg::ST_IDLE;
            end
        endcase
    end

    `OBPL_ASSERT_ALWAYS(a_no_overlap, !(in_ready && out_valid))
    `OBPL_ASSERT_NEXT(a_load_then_apply, cmd.load, cmd.apply)
    `OBPL_ASSERT_NEXT(a_apply_then_result, cmd.apply, out_valid)
endmodule
`default_nettype wire

[rtl/obpl_dp.sv]
// ----------------------------------------------------------------------------
// Order book datapath
// Sorted bid and ask level chains with per-cell insert, update and remove.
// ----------------------------------------------------------------------------
`default_nettype none
module obpl_dp (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire obpl_pkg::cmd_t               cmd,
    input  wire logic [1:0]                   kind,
    input  wire logic                         side,
    input  wire logic [obpl_pkg::PRICE_W-1:0] price,
    input  wire logic [obpl_pkg::QTY_W-1:0]   quantity,
    input  wire logic [obpl_pkg::ID_W-1:0]    update_id,
    output logic [obpl_pkg::PRICE_W-1:0]      best_bid_price,
    output logic [obpl_pkg::QTY_W-1:0]        best_bid_qty,
    output logic                              bid_valid,
    output logic [obpl_pkg::PRICE_W-1:0]      best_ask_price,
    output logic [obpl_pkg::QTY_W-1:0]        best_ask_qty,
    output logic                              ask_valid,
    output logic                              ignored,
    output logic                              table_full
);
    localparam int N = obpl_pkg::LEVELS;

    obpl_pkg::kind_t                  kind_reg;
    logic                             side_reg;
    logic [obpl_pkg::PRICE_W-1:0]     price_reg;
    logic [obpl_pkg::QTY_W-1:0]       qty_reg;
    logic [obpl_pkg::ID_W-1:0]        uid_reg;

    logic [obpl_pkg::PRICE_W-1:0]     bid_p_reg [N];
    logic [obpl_pkg::QTY_W-1:0]       bid_q_reg [N];
    logic [obpl_pkg::PRICE_W-1:0]     ask_p_reg [N];
    logic [obpl_pkg::QTY_W-1:0]       ask_q_reg [N];
    logic [obpl_pkg::CNT_W-1:0]       bid_cnt_reg, bid_cnt_next;
    logic [obpl_pkg::CNT_W-1:0]       ask_cnt_reg, ask_cnt_next;
    logic [obpl_pkg::ID_W-1:0]        sid_reg, sid_next;
    logic                             ready_reg, ready_next;
    logic                             ign_reg, ign_next;
    logic                             full_reg, full_next;

    logic [obpl_pkg::PRICE_W-1:0]     sel_p [N];
    logic [obpl_pkg::QTY_W-1:0]       sel_q [N];
    logic [obpl_pkg::PRICE_W-1:0]     new_p [N];
    logic [obpl_pkg::QTY_W-1:0]       new_q [N];
    logic [N-1:0]                     better;
    logic [N-1:0]                     match;
    logic [obpl_pkg::CNT_W-1:0]       sel_cnt, new_cnt;
    logic                             any_match, stale, do_set, do_rem, wr_side;

    always_comb
    begin
        sel_cnt = side_reg ? ask_cnt_reg : bid_cnt_reg;
        for (int i = 0; i < N; i++)
        begin
            sel_p[i]  = side_reg ? ask_p_reg[i] : bid_p_reg[i];
            sel_q[i]  = side_reg ? ask_q_reg[i] : bid_q_reg[i];
            better[i] = (obpl_pkg::CNT_W'(i) < sel_cnt) &&
                        (side_reg ? (sel_p[i] < price_reg) : (sel_p[i] > price_reg));
            match[i]  = (obpl_pkg::CNT_W'(i) < sel_cnt) && (sel_p[i] == price_reg);
        end
        any_match = |match;
        stale     = ready_reg && (uid_reg <= sid_reg);

        do_set     = 1'b0;
        do_rem     = 1'b0;
        ign_next   = 1'b0;
        full_next  = 1'b0;
        sid_next   = sid_reg;
        ready_next = ready_reg;
        case (kind_reg)
            obpl_pkg::KIND_DIFF_LEVEL:
            begin
                if (stale)
                begin
                    ign_next = 1'b1;
                end
                else if (qty_reg == '0)
                begin
                    do_rem = 1'b1;
                end
                else
                begin
                    do_set = 1'b1;
                end
            end
            obpl_pkg::KIND_DIFF_COMMIT:
            begin
                if (stale)
                begin
                    ign_next = 1'b1;
                end
                else
                begin
                    sid_next   = uid_reg;
                    ready_next = 1'b1;
                end
            end
            obpl_pkg::KIND_SNAP_CLEAR:
            begin
                ready_next = 1'b1;
            end
            obpl_pkg::KIND_SNAP_LEVEL:
            begin
                do_set     = 1'b1;
                ready_next = 1'b1;
            end
            default:
            begin
                ready_next = ready_reg;
            end
        endcase

        new_cnt = sel_cnt;
        wr_side = 1'b0;
        for (int i = 0; i < N; i++)
        begin
            new_p[i] = sel_p[i];
            new_q[i] = sel_q[i];
        end
        if (do_set && any_match)
        begin
            wr_side = 1'b1;
            for (int i = 0; i < N; i++)
            begin
                if (match[i])
                begin
                    new_q[i] = qty_reg;
                end
            end
        end
        else if (do_set && (sel_cnt == obpl_pkg::CNT_W'(N)))
        begin
            full_next = 1'b1;
        end
        else if (do_set)
        begin
            wr_side = 1'b1;
            new_cnt = sel_cnt + 1'b1;
            for (int i = 0; i < N; i++)
            begin
                if (!better[i])
                begin
                    if (i == 0)
                    begin
                        new_p[i] = price_reg;
                        new_q[i] = qty_reg;
                    end
                    else if (better[i-1])
                    begin
                        new_p[i] = price_reg;
                        new_q[i] = qty_reg;
                    end
                    else
                    begin
                        new_p[i] = sel_p[i-1];
                        new_q[i] = sel_q[i-1];
                    end
                end
            end
        end
        else if (do_rem && any_match)
        begin
            wr_side = 1'b1;
            new_cnt = sel_cnt - 1'b1;
            for (int i = 0; i < N - 1; i++)
            begin
                if (!better[i])
                begin
                    new_p[i] = sel_p[i+1];
                    new_q[i] = sel_q[i+1];
                end
            end
        end

        bid_cnt_next = bid_cnt_reg;
        ask_cnt_next = ask_cnt_reg;
        if (kind_reg == obpl_pkg::KIND_SNAP_CLEAR)
        begin
            bid_cnt_next = '0;
            ask_cnt_next = '0;
        end
        else if (wr_side && side_reg)
        begin
            ask_cnt_next = new_cnt;
        end
        else if (wr_side)
        begin
            bid_cnt_next = new_cnt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= obpl_pkg::kind_t'(kind);
            side_reg  <= side;
            price_reg <= price;
            qty_reg   <= quantity;
            uid_reg   <= update_id;
        end
        if (cmd.apply && wr_side)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (side_reg)
                begin
                    ask_p_reg[i] <= new_p[i];
                    ask_q_reg[i] <= new_q[i];
                end
                else
                begin
                    bid_p_reg[i] <= new_p[i];
                    bid_q_reg[i] <= new_q[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bid_cnt_reg <= '0;
            ask_cnt_reg <= '0;
            sid_reg     <= '0;
            ready_reg   <= 1'b0;
            ign_reg     <= 1'b0;
            full_reg    <= 1'b0;
        end
        else if (cmd.apply)
        begin
            bid_cnt_reg <= bid_cnt_next;
            ask_cnt_reg <= ask_cnt_next;
            sid_reg     <= sid_next;
            ready_reg   <= ready_next;
            ign_reg     <= ign_next;
            full_reg    <= full_next;
        end
    end

    assign bid_valid      = (bid_cnt_reg != '0);
    assign ask_valid      = (ask_cnt_reg != '0);
    assign best_bid_price = bid_valid ? bid_p_reg[0] : '0;
    assign best_bid_qty   = bid_valid ? bid_q_reg[0] : '0;
    assign best_ask_price = ask_valid ? ask_p_reg[0] : '0;
    assign best_ask_qty   = ask_valid ? ask_q_reg[0] : '0;
    assign ignored        = ign_reg;
    assign table_full     = full_reg;
endmodule
`default_nettype wire

[rtl/order_book_price_levels.sv]
// Sequence: the input beat is registered, the apply state updates the table, then the result beat.
// Items: one at a time; the next item is taken only after the
// result beat leaves, set by the single-item controller sequence.
// Reset: asynchronous active low; empties both tables, clears stored id and ready flag.
// ----------------------------------------------------------------------------
// Order book price levels
// Top level joining the controller and the sorted level datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module order_book_price_levels (
    input  wire logic clk,
    input  wire logic rst_n,
    obpl_in_if.sink   req,
    obpl_out_if.source rsp
);
    obpl_pkg::cmd_t cmd;

    obpl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    obpl_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .kind           (req.kind),
        .side           (req.side),
        .price          (req.price),
        .quantity       (req.quantity),
        .update_id      (req.update_id),
        .best_bid_price (rsp.best_bid_price),
        .best_bid_qty   (rsp.best_bid_qty),
        .bid_valid      (rsp.bid_valid),
        .best_ask_price (rsp.best_ask_price),
        .best_ask_qty   (rsp.best_ask_qty),
        .ask_valid      (rsp.ask_valid),
        .ignored        (rsp.ignored),
        .table_full     (rsp.table_full)
    );
endmodule
`default_nettype wire
